// ===== sv/bfop_pkg.sv =====
// Package for the best-fit offset planner: widths, span type, span ordering.
// No dependencies.
`default_nettype none
package bfop_pkg;
    localparam int OFF_W       = 38;
    localparam int SIZE_W      = 32;
    localparam int TIME_W      = 16;
    localparam int SPAN_W      = 39;
    localparam int MAX_ENTRIES = 64;

    typedef struct packed {
        logic              vld;
        logic [SPAN_W-1:0] lo;
        logic [SPAN_W-1:0] hi;
    } t_span;

    function automatic logic span_less(input t_span a, input t_span b);
        span_less = (a.lo < b.lo) || ((a.lo == b.lo) && (a.hi < b.hi));
    endfunction
endpackage
`default_nettype wire

// ===== sv/bfop_sort_cell.sv =====
// One cell of the insertion-sort chain: holds one span, passes the larger on
// through a register to its neighbor. Depends on bfop_pkg.
`default_nettype none
module bfop_sort_cell
    import bfop_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_clr,
    input  wire logic  i_shift,
    input  wire t_span i_in,
    input  wire t_span i_tail,
    output t_span      o_out,
    output t_span      o_held
);
    t_span r_held;
    t_span n_held;
    t_span r_pass;
    t_span n_pass;

    always_comb begin
        n_held = r_held;
        n_pass = '0;
        if (i_shift) begin
            n_held = i_tail;
        end else if (i_in.vld) begin
            if (!r_held.vld) begin
                n_held = i_in;
            end else if (span_less(i_in, r_held)) begin
                n_held = i_in;
                n_pass = r_held;
            end else begin
                n_pass = i_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_held <= '0;
            r_pass <= '0;
        end else begin
            r_held <= n_held;
            r_pass <= n_pass;
        end
    end

    assign o_out  = r_pass;
    assign o_held = r_held;
endmodule
`default_nettype wire

// ===== sv/best_fit_offset_planner.sv =====
// Top level of the best-fit offset planner: entry table, sort chain, gap scan.
// Depends on bfop_pkg and bfop_sort_cell.
//
// channel  dir  ports                                            timing
// command  in   i_start/o_busy, i_first_item, i_alloc_size, ...  taken when !o_busy
// result   out  o_done, o_placed_offset, o_table_full            one-cycle strobe
//
// With N stored entries an item passes through these states in order: S_READ makes
// the N table reads that feed the span chain, S_LAST lets the chain settle, S_SCAN
// shifts it out into the gap scan, S_WB registers the offset, and S_DONE writes the
// new entry and strobes. A full table strobes in the cycle right after acceptance.
// Reset empties the table at once.
// The result cannot be stalled; o_busy stays high until the strobe cycle ends.
`default_nettype none
module best_fit_offset_planner
    import bfop_pkg::*;
#(
    parameter int P_MAX_ENTRIES = MAX_ENTRIES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic              i_first_item,
    input  wire logic [SIZE_W-1:0] i_alloc_size,
    input  wire logic [TIME_W-1:0] i_live_start,
    input  wire logic [TIME_W-1:0] i_live_end,
    output logic                   o_done,
    output logic [OFF_W-1:0]       o_placed_offset,
    output logic                   o_table_full
);
    localparam int AW = $clog2(P_MAX_ENTRIES);
    localparam int CW = $clog2(P_MAX_ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [TIME_W-1:0] m_ls  [P_MAX_ENTRIES];
    logic [TIME_W-1:0] m_le  [P_MAX_ENTRIES];
    logic [SIZE_W-1:0] m_sz  [P_MAX_ENTRIES];
    logic [OFF_W-1:0]  m_off [P_MAX_ENTRIES];

    logic [2:0]        r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic              r_rd_vld;
    logic [TIME_W-1:0] r_rd_ls, r_rd_le;
    logic [SIZE_W-1:0] r_rd_sz;
    logic [OFF_W-1:0]  r_rd_off;
    logic [SIZE_W-1:0] r_size;
    logic [TIME_W-1:0] r_ls, r_le;
    logic [SPAN_W-1:0] r_cursor, r_best_off, r_best_gap;
    logic              r_have_best;
    logic              r_clr;
    logic [OFF_W-1:0]  r_out_off;
    logic              r_out_full;

    t_span w_feed;
    t_span w_link [P_MAX_ENTRIES+1];
    t_span w_held [P_MAX_ENTRIES];
    logic  w_shift;

    always_comb begin
        w_feed.vld = r_rd_vld && (r_ls < r_rd_le) && (r_rd_ls < r_le);
        w_feed.lo  = {1'b0, r_rd_off};
        w_feed.hi  = {1'b0, r_rd_off} + {{(SPAN_W-SIZE_W){1'b0}}, r_rd_sz};
    end

    assign w_shift   = (r_state == S_SCAN);
    assign w_link[0] = w_feed;

    for (genvar g = 0; g < P_MAX_ENTRIES; g++) begin : g_cell
        bfop_sort_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (r_clr),
            .i_shift (w_shift),
            .i_in    (w_link[g]),
            .i_tail  ((g == P_MAX_ENTRIES-1) ? t_span'('0) : w_held[(g+1) % P_MAX_ENTRIES]),
            .o_out   (w_link[g+1]),
            .o_held  (w_held[g])
        );
    end

    t_span             w_head;
    logic [SPAN_W-1:0] w_gap;
    logic              w_fit;
    assign w_head = w_held[0];
    assign w_gap  = w_head.lo - r_cursor;
    assign w_fit  = (w_head.lo >= r_cursor) && (w_gap >= {7'd0, r_size})
                    && (!r_have_best || (w_gap < r_best_gap));

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_ls  <= m_ls[r_idx[AW-1:0]];
            r_rd_le  <= m_le[r_idx[AW-1:0]];
            r_rd_sz  <= m_sz[r_idx[AW-1:0]];
            r_rd_off <= m_off[r_idx[AW-1:0]];
        end
        if (r_state == S_DONE && !r_out_full) begin
            m_ls[r_count[AW-1:0]]  <= r_ls;
            m_le[r_count[AW-1:0]]  <= r_le;
            m_sz[r_count[AW-1:0]]  <= r_size;
            m_off[r_count[AW-1:0]] <= r_out_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_clr    <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_clr    <= 1'b0;
            r_rd_vld <= (r_state == S_READ);
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_size      <= i_alloc_size;
                        r_ls        <= i_live_start;
                        r_le        <= i_live_end;
                        r_idx       <= '0;
                        r_cursor    <= '0;
                        r_best_off  <= '0;
                        r_best_gap  <= '0;
                        r_have_best <= 1'b0;
                        r_clr       <= 1'b1;
                        if (i_first_item) begin
                            r_count <= '0;
                        end
                        if (!i_first_item && r_count == CW'(P_MAX_ENTRIES)) begin
                            r_out_off  <= '0;
                            r_out_full <= 1'b1;
                            r_state    <= S_DONE;
                        end else begin
                            r_out_full <= 1'b0;
                            r_state    <= ((i_first_item ? '0 : r_count) == '0)
                                          ? S_LAST : S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (r_idx + 1'b1 == r_count) begin
                        r_idx   <= '0;
                        r_state <= S_LAST;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_LAST: begin
                    if (r_idx == CW'(P_MAX_ENTRIES - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (w_head.vld) begin
                        if (w_fit) begin
                            r_have_best <= 1'b1;
                            r_best_gap  <= w_gap;
                            r_best_off  <= r_cursor;
                        end
                        if (w_head.hi > r_cursor) begin
                            r_cursor <= w_head.hi;
                        end
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == CW'(P_MAX_ENTRIES - 1)) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_out_off <= r_have_best ? r_best_off[OFF_W-1:0]
                                             : r_cursor[OFF_W-1:0];
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_full) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = (r_state == S_DONE);
    assign o_placed_offset = r_out_off;
    assign o_table_full    = r_out_full;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(P_MAX_ENTRIES)) else $error("entry count overflow");
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_table_full |-> o_placed_offset == '0) else $error("full with offset");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
endmodule
`default_nettype wire
